/* src/splc_pkg.sv */
// Shared types and constants of the serial password lock controller.
// Used by splc_front, splc_queue, splc_back and the top level; depends on nothing.
package splc_pkg;

	localparam int CountW     = 5;
	localparam int StoreDepth = 14;
	localparam int IdxW       = 4;
	localparam int QueueDepth = 2;
	localparam int PwW        = 48;

	localparam logic [7:0] END_MARK     = 8'h23;
	localparam logic [7:0] REPLY_CLOSE  = 8'h30;
	localparam logic [7:0] REPLY_OWNER  = 8'h31;
	localparam logic [7:0] REPLY_USER   = 8'h32;
	localparam logic [7:0] REPLY_GUEST  = 8'h33;
	localparam logic [7:0] REPLY_FAIL   = 8'h38;

	localparam logic [7:0] CMD_CLOSE  = 8'h00;
	localparam logic [7:0] CMD_UNLOCK = 8'h01;
	localparam logic [7:0] CMD_CHANGE = 8'h02;
	localparam logic [7:0] CMD_SHARE  = 8'h03;

	localparam logic [7:0] CLASS_OWNER = 8'h01;
	localparam logic [7:0] CLASS_USER  = 8'h02;
	localparam logic [7:0] CLASS_GUEST = 8'h03;

	localparam logic [5:0] MIN_LEN_CHECK  = 6'd8;
	localparam logic [5:0] MIN_LEN_CHANGE = 6'd15;

	// Index of the final byte of a share run: code, six user bytes, six guest bytes
	localparam logic [IdxW-1:0] SHARE_LAST = 4'd12;

	localparam logic [PwW-1:0] PW_OWNER_INIT = 48'h313238313238;
	localparam logic [PwW-1:0] PW_USER_INIT  = 48'h323831323831;
	localparam logic [PwW-1:0] PW_GUEST_INIT = 48'h383132383132;

	typedef struct packed {
		logic             share;
		logic [7:0]       code;
		logic             pulse;
		logic [2*PwW-1:0] data;
	} job_t;

endpackage

/* src/splc_front.sv */
// Front part: collects received bytes into a frame and decides each frame at its end mark.
// Holds the passwords; pushes one job per frame into the queue. Depends on splc_pkg.
module splc_front #(
	parameter int FRAME_LIMIT = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	output logic              push,
	output splc_pkg::job_t    job
);
	import splc_pkg::*;

	localparam logic [5:0] LIMIT_L = 6'(FRAME_LIMIT);

	logic [CountW-1:0] count_q;
	logic [7:0]        store_q [StoreDepth];
	logic [PwW-1:0]    owner_q;
	logic [PwW-1:0]    user_q;
	logic [PwW-1:0]    guest_q;

	logic [5:0]     len;
	logic           overflow;
	logic           is_end;
	logic [7:0]     cmd;
	logic [PwW-1:0] pw_in;
	logic [PwW-1:0] pw_new;
	logic           owner_hit;
	logic           user_hit;
	logic           guest_hit;
	logic           set_owner;
	logic           set_user;
	logic           set_guest;

	assign len       = {1'b0, count_q} + 6'd1;
	assign overflow  = len > LIMIT_L;
	assign is_end    = rx_byte == END_MARK;
	assign pw_in     = {store_q[1], store_q[2], store_q[3], store_q[4], store_q[5], store_q[6]};
	assign pw_new    = {store_q[8], store_q[9], store_q[10], store_q[11], store_q[12],
		store_q[13]};
	assign owner_hit = pw_in == owner_q;
	assign user_hit  = pw_in == user_q;
	assign guest_hit = pw_in == guest_q;
	assign push      = take && is_end;

	always_comb begin
		// an overflowing frame is dropped and then reads as a close command
		if (overflow)
			cmd = CMD_CLOSE;
		else if (count_q == '0)
			cmd = rx_byte;
		else
			cmd = store_q[0];

		job.share = 1'b0;
		job.code  = REPLY_FAIL;
		job.pulse = 1'b0;
		job.data  = {user_q, guest_q};
		set_owner = 1'b0;
		set_user  = 1'b0;
		set_guest = 1'b0;

		unique case (cmd)
			CMD_CLOSE: begin
				job.code = REPLY_CLOSE;
			end
			CMD_UNLOCK: begin
				if (len >= MIN_LEN_CHECK) begin
					if (owner_hit) begin
						job.code  = REPLY_OWNER;
						job.pulse = 1'b1;
					end else if (user_hit) begin
						job.code  = REPLY_USER;
						job.pulse = 1'b1;
					end else if (guest_hit) begin
						job.code  = REPLY_GUEST;
						job.pulse = 1'b1;
					end
				end
			end
			CMD_CHANGE: begin
				if (len >= MIN_LEN_CHANGE && owner_hit) begin
					unique case (store_q[7])
						CLASS_OWNER: begin
							set_owner = 1'b1;
							job.code  = REPLY_OWNER;
						end
						CLASS_USER: begin
							set_user = 1'b1;
							job.code = REPLY_USER;
						end
						CLASS_GUEST: begin
							set_guest = 1'b1;
							job.code  = REPLY_GUEST;
						end
						default: begin
							job.code = REPLY_FAIL;
						end
					endcase
				end
			end
			CMD_SHARE: begin
				if (len >= MIN_LEN_CHECK && owner_hit) begin
					job.share = 1'b1;
					job.code  = REPLY_USER;
				end
			end
			default: begin
				job.code = REPLY_FAIL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			owner_q <= PW_OWNER_INIT;
			user_q  <= PW_USER_INIT;
			guest_q <= PW_GUEST_INIT;
		end else if (take) begin
			if (overflow || is_end)
				count_q <= '0;
			else
				count_q <= len[CountW-1:0];
			if (push && set_owner)
				owner_q <= pw_new;
			if (push && set_user)
				user_q <= pw_new;
			if (push && set_guest)
				guest_q <= pw_new;
		end
	end

	// bytes past the store are counted only
	always_ff @(posedge clk) begin
		if (take && count_q < CountW'(StoreDepth))
			store_q[count_q[IdxW-1:0]] <= rx_byte;
	end

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= LIMIT_L)
		else $error("frame count above limit");

endmodule

/* src/splc_queue.sv */
// Short job queue between the front and back parts.
// Two entries of splc_pkg::job_t; depends on splc_pkg.
module splc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  splc_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output splc_pkg::job_t rd_job
);
	import splc_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);

	job_t            mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   fill_q;

	assign full     = fill_q == (PtrW+1)'(QueueDepth);
	assign nonempty = fill_q != '0;
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty queue");

endmodule

/* src/splc_back.sv */
// Back part: takes jobs from the queue and plays out their reply bytes.
// A share job gives the code and then twelve password bytes; depends on splc_pkg.
module splc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           nonempty,
	input  splc_pkg::job_t rd_job,
	output logic           pop,
	output logic           reply_valid,
	input  logic           reply_ready,
	output logic [7:0]     reply_byte,
	output logic           last_reply,
	output logic           unlock_pulse
);
	import splc_pkg::*;

	logic             active_q;
	logic             share_q;
	logic             pulse_q;
	logic [7:0]       code_q;
	logic [2*PwW-1:0] data_q;
	logic [IdxW-1:0]  idx_q;
	logic             step;
	logic             done;

	assign reply_valid  = active_q;
	assign reply_byte   = (idx_q == '0) ? code_q : data_q[2*PwW-1 -: 8];
	assign last_reply   = !share_q || idx_q == SHARE_LAST;
	assign unlock_pulse = pulse_q;
	assign step         = active_q && reply_ready;
	assign done         = step && last_reply;
	assign pop          = nonempty && (!active_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (done) begin
			active_q <= 1'b0;
		end else if (step) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			share_q <= rd_job.share;
			pulse_q <= rd_job.pulse;
			code_q  <= rd_job.code;
			data_q  <= rd_job.data;
		end else if (step && idx_q != '0) begin
			// advance to the next password byte
			data_q <= {data_q[2*PwW-9:0], 8'h00};
		end
	end

	a_pulse_single: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && unlock_pulse |-> last_reply && idx_q == '0)
		else $error("unlock pulse outside a single reply");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last_reply |=> reply_valid && idx_q == $past(idx_q) + 1'b1)
		else $error("share run broken");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> idx_q <= SHARE_LAST)
		else $error("reply index out of range");

endmodule

/* src/serial_password_lock_controller.sv */
// Top level of the serial password lock controller.
// Joins splc_front, splc_queue and splc_back; depends on splc_pkg.
//
// channel | handshake                  | payload
// rx      | rx_valid / rx_ready        | rx_byte
// reply   | reply_valid / reply_ready  | reply_byte, last_reply, unlock_pulse
//
// A byte is taken when rx_valid meets rx_ready; one byte per cycle is sustained while the
// two-entry job queue has room. The front decides a frame in the cycle its end mark is
// taken. The back plays one reply byte per ready cycle: one for most frames, 13 for a share.
// Reset clears the frame count, the queue and the back, and restores the three passwords.
// A stalled reply side fills the queue, after which rx_ready drops until a job leaves.
module serial_password_lock_controller #(
	parameter int FRAME_LIMIT = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       reply_valid,
	input  logic       reply_ready,
	output logic [7:0] reply_byte,
	output logic       last_reply,
	output logic       unlock_pulse
);
	import splc_pkg::*;

	logic take;
	logic push;
	logic full;
	logic pop;
	logic nonempty;
	job_t wr_job;
	job_t rd_job;

	assign rx_ready = !full;
	assign take     = rx_valid && rx_ready;

	splc_front #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.push    (push),
		.job     (wr_job)
	);

	splc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (wr_job),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.rd_job   (rd_job)
	);

	splc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.nonempty     (nonempty),
		.rd_job       (rd_job),
		.pop          (pop),
		.reply_valid  (reply_valid),
		.reply_ready  (reply_ready),
		.reply_byte   (reply_byte),
		.last_reply   (last_reply),
		.unlock_pulse (unlock_pulse)
	);

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for serial_password_lock_controller: frames of random and
// directed bytes go in, every reply is checked against a frame-level predictor.
// Depends on splc_pkg and the RTL under src/.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import splc_pkg::*;

	localparam int FRAME_LIMIT = 18;
	localparam logic [7:0] CLASS_NONE = 8'h00;
	localparam int RANDOM_BYTES = 250;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       pulse;
	} reply_t;

	class lock_scoreboard;
		logic [7:0]        frame_bytes [StoreDepth];
		logic [CountW-1:0] rx_count;
		logic [PwW-1:0]    owner_pw;
		logic [PwW-1:0]    user_pw;
		logic [PwW-1:0]    guest_pw;
		reply_t            replies_due [$];
		int                mismatches;

		function new();
			clear_frame();
			owner_pw = PW_OWNER_INIT;
			user_pw = PW_USER_INIT;
			guest_pw = PW_GUEST_INIT;
			mismatches = 0;
		endfunction

		function void clear_frame();
			foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
			rx_count = '0;
		endfunction

		function logic [PwW-1:0] pack_six(int first);
			logic [PwW-1:0] v;
			v = '0;
			for (int k = 0; k < 6; k++) v = {v[PwW-9:0], frame_bytes[first + k]};
			return v;
		endfunction

		function logic [7:0] match_class(logic [PwW-1:0] pw);
			if (pw == owner_pw) return CLASS_OWNER;
			if (pw == user_pw) return CLASS_USER;
			if (pw == guest_pw) return CLASS_GUEST;
			return CLASS_NONE;
		endfunction

		function logic [7:0] code_of(logic [7:0] cls);
			case (cls)
				CLASS_OWNER: return REPLY_OWNER;
				CLASS_USER:  return REPLY_USER;
				CLASS_GUEST: return REPLY_GUEST;
				default:     return REPLY_FAIL;
			endcase
		endfunction

		function void queue_reply(logic [7:0] code, logic last, logic pulse);
			reply_t r;
			r.code = code;
			r.last = last;
			r.pulse = pulse;
			replies_due.push_back(r);
		endfunction

		// Advance the frame by one transferred byte and queue the replies it causes.
		function void note_byte(logic [7:0] b);
			int             len;
			logic [7:0]     cls;
			logic [7:0]     reply;
			logic           pulse;
			logic [PwW-1:0] npw;
			len = rx_count + 1;
			if (rx_count < StoreDepth) frame_bytes[rx_count] = b;
			rx_count = len[CountW-1:0];
			if (len > FRAME_LIMIT) begin
				clear_frame();
				len = 0;
			end
			if (b != END_MARK) return;
			reply = REPLY_FAIL;
			pulse = 1'b0;
			case (frame_bytes[0])
				CMD_CLOSE: reply = REPLY_CLOSE;
				CMD_UNLOCK: begin
					if (len >= MIN_LEN_CHECK) begin
						cls = match_class(pack_six(1));
						if (cls != CLASS_NONE) begin
							reply = code_of(cls);
							pulse = 1'b1;
						end
					end
				end
				CMD_CHANGE: begin
					if (len >= MIN_LEN_CHANGE && match_class(pack_six(1)) == CLASS_OWNER) begin
						npw = pack_six(8);
						case (frame_bytes[7])
							CLASS_OWNER: owner_pw = npw;
							CLASS_USER:  user_pw = npw;
							CLASS_GUEST: guest_pw = npw;
							default: ;
						endcase
						reply = code_of(frame_bytes[7]);
					end
				end
				CMD_SHARE: begin
					if (len >= MIN_LEN_CHECK && match_class(pack_six(1)) == CLASS_OWNER) begin
						queue_reply(REPLY_USER, 1'b0, 1'b0);
						for (int k = 0; k < 6; k++) queue_reply(user_pw[8*(5-k) +: 8], 1'b0, 1'b0);
						for (int k = 0; k < 6; k++)
							queue_reply(guest_pw[8*(5-k) +: 8], k == 5, 1'b0);
						clear_frame();
						return;
					end
				end
				default: ;
			endcase
			queue_reply(reply, 1'b1, pulse);
			clear_frame();
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_reply(logic [7:0] b, logic last, logic pulse);
			reply_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("reply %02h arrived with nothing pending", b));
				return;
			end
			want = replies_due.pop_front();
			if (b !== want.code)
				report($sformatf("reply_byte %02h, want %02h", b, want.code));
			if (last !== want.last)
				report($sformatf("last_reply %b, want %b (byte %02h)", last, want.last, want.code));
			if (pulse !== want.pulse)
				report($sformatf("unlock_pulse %b, want %b (byte %02h)", pulse, want.pulse,
					want.code));
		endtask

		function int pending();
			return replies_due.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       reply_valid;
	logic       reply_ready = 1'b0;
	logic [7:0] reply_byte;
	logic       last_reply;
	logic       unlock_pulse;

	lock_scoreboard sb;
	logic [7:0]     frame_q [$];
	int             bytes_sent = 0;
	bit             steady = 1'b0;

	serial_password_lock_controller #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.reply_valid(reply_valid),
		.reply_ready(reply_ready),
		.reply_byte(reply_byte),
		.last_reply(last_reply),
		.unlock_pulse(unlock_pulse)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (b == END_MARK) b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic logic [PwW-1:0] random_pw();
		logic [PwW-1:0] pw;
		for (int k = 0; k < 6; k++) pw[8*k +: 8] = body_byte();
		return pw;
	endfunction

	function automatic void add_pw(logic [PwW-1:0] pw);
		for (int k = 0; k < 6; k++) frame_q.push_back(pw[8*(5-k) +: 8]);
	endfunction

	function automatic void add_filler(int n);
		for (int k = 0; k < n; k++) frame_q.push_back(body_byte());
	endfunction

	function automatic void truncate_to(int n);
		while (frame_q.size() > n) void'(frame_q.pop_back());
	endfunction

	// Hold the byte until it is taken; drop valid only when a gap is drawn.
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!rx_ready) @(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame();
		steady = ($urandom_range(0, 3) == 0);
		foreach (frame_q[i]) send_byte(frame_q[i]);
		frame_q.delete();
	endtask

	function automatic logic [PwW-1:0] owner_or_wrong();
		return ($urandom_range(0, 4) == 0) ? random_pw() : sb.owner_pw;
	endfunction

	task automatic random_frame();
		int             kind;
		logic [7:0]     cls;
		logic [PwW-1:0] pw;
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				frame_q.push_back(CMD_CLOSE);
				add_filler($urandom_range(0, 4));
			end
			1, 2, 9: begin
				case ($urandom_range(0, 4))
					0: pw = sb.owner_pw;
					1: pw = sb.user_pw;
					2: pw = sb.guest_pw;
					default: pw = (kind == 9) ? sb.owner_pw : random_pw();
				endcase
				frame_q.push_back(CMD_UNLOCK);
				add_pw(pw);
				if ($urandom_range(0, 5) == 0) truncate_to($urandom_range(1, 6));
				add_filler($urandom_range(0, 2));
			end
			3, 4: begin
				case ($urandom_range(0, 9))
					0: cls = CLASS_OWNER;
					1, 2, 3, 4: cls = CLASS_USER;
					5, 6, 7, 8: cls = CLASS_GUEST;
					default: cls = body_byte();
				endcase
				frame_q.push_back(CMD_CHANGE);
				add_pw(owner_or_wrong());
				frame_q.push_back(cls);
				add_pw(random_pw());
				if ($urandom_range(0, 4) == 0) truncate_to($urandom_range(7, 13));
			end
			5: begin
				frame_q.push_back(CMD_SHARE);
				add_pw(owner_or_wrong());
				add_filler($urandom_range(0, 3));
			end
			6: begin
				if ($urandom_range(0, 3) != 0) begin
					frame_q.push_back(body_byte());
					if (frame_q[0] <= CMD_SHARE) frame_q[0] = 8'hA5;
					add_filler($urandom_range(0, 8));
				end
			end
			7: add_filler($urandom_range(14, 24));
			default: begin
				// broken sequence: no end mark, so it spills into the next frame
				for (int k = $urandom_range(1, 10); k > 0; k--)
					frame_q.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		if (kind != 8) frame_q.push_back(END_MARK);
		send_frame();
	endtask

	initial begin : stimulus
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone end mark, then close
		frame_q.push_back(END_MARK);
		send_frame();
		frame_q.push_back(CMD_CLOSE);
		frame_q.push_back(END_MARK);
		send_frame();
		// unlock as user, share as owner, top byte as a command, short unlock
		frame_q.push_back(CMD_UNLOCK);
		add_pw(PW_USER_INIT);
		frame_q.push_back(END_MARK);
		send_frame();
		frame_q.push_back(CMD_SHARE);
		add_pw(PW_OWNER_INIT);
		frame_q.push_back(END_MARK);
		send_frame();
		frame_q.push_back(8'hFF);
		frame_q.push_back(END_MARK);
		send_frame();
		frame_q.push_back(CMD_UNLOCK);
		frame_q.push_back(8'h31);
		frame_q.push_back(END_MARK);
		send_frame();

		while (bytes_sent < RANDOM_BYTES) random_frame();
		rx_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : reply_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				reply_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			reply_ready <= 1'b1;
			@(posedge clk);
			while (!reply_valid) @(posedge clk);
			sb.check_reply(reply_byte, last_reply, unlock_pulse);
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
src/splc_pkg.sv
src/splc_front.sv
src/splc_queue.sv
src/splc_back.sv
src/serial_password_lock_controller.sv
tb/sv/testbench.sv
